// ===== src/rpsas_pkg.sv =====
// shared widths and register indexes for the rns plaintext scale add/sub block
// no dependencies
package rpsas_pkg;

  localparam int unsigned W      = 60;
  localparam int unsigned HALF_W = 30;
  localparam int unsigned QUO_W  = 64;
  localparam int unsigned NUM_W  = 121;
  localparam int unsigned MAXL   = 3;
  localparam int unsigned ADDR_W = 3;

  localparam logic [ADDR_W-1:0] REG_PLAIN_MOD = 3'd0;
  localparam logic [ADDR_W-1:0] REG_BIG_MOD   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_LIMB_Q0   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_LIMB_Q1   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_LIMB_Q2   = 3'd4;
  localparam logic [ADDR_W-1:0] REG_DELTA0    = 3'd5;
  localparam logic [ADDR_W-1:0] REG_DELTA1    = 3'd6;
  localparam logic [ADDR_W-1:0] REG_DELTA2    = 3'd7;

endpackage

// ===== src/rns_plain_scale_add_sub.sv =====
// top level: config registers, rounding-fix datapath and the per-limb lanes
// depends on rpsas_pkg, rpsas_mul, rpsas_div, rpsas_lane
//
//   port group   direction  contents
//   in_*         slave      tdata plain_coeff, dest_in_0..2; tuser command
//   out_*        master     tdata dest_out_0..2
//   cfg_*        write      register index and 60-bit value
//
// one transaction per cycle while the output is not stalled; the path runs through two 121-stage dividers
// in series (rounding fix, then limb remainder)
// rst_n clears the valid chain and loads the register reset values
// a stalled output freezes the whole pipeline; in_tready follows out_tready then
module rns_plain_scale_add_sub import rpsas_pkg::*; #(
  parameter int unsigned LIMBS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [239:0]      in_tdata,   // plain_coeff, dest_in_0, dest_in_1, dest_in_2
  input  logic              in_tuser,   // command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [183:0]      out_tdata,  // dest_out_0, dest_out_1, dest_out_2, zero pad
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [W-1:0]      cfg_wdata
);

  localparam int unsigned LAT  = 2 * NUM_W + 5;
  localparam int unsigned SIDE = 1 + 4 * W;

  logic [W-1:0] plain_mod_r, big_mod_r;
  logic [W-1:0] limb_q_r [MAXL];
  logic [W-1:0] delta_r  [MAXL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_mod_r <= W'(2);
      big_mod_r   <= '0;
      for (int j = 0; j < MAXL; j++) begin
        limb_q_r[j] <= W'(2);
        delta_r[j]  <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PLAIN_MOD: plain_mod_r <= cfg_wdata;
        REG_BIG_MOD:   big_mod_r   <= cfg_wdata;
        REG_LIMB_Q0:   limb_q_r[0] <= cfg_wdata;
        REG_LIMB_Q1:   limb_q_r[1] <= cfg_wdata;
        REG_LIMB_Q2:   limb_q_r[2] <= cfg_wdata;
        REG_DELTA0:    delta_r[0]  <= cfg_wdata;
        REG_DELTA1:    delta_r[1]  <= cfg_wdata;
        REG_DELTA2:    delta_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic           adv;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];

  // rounding fix
  logic [W:0]       t_plus;
  logic [QUO_W-1:0] half;
  logic [NUM_W-1:0] fix_num;
  logic [SIDE-1:0]  side_mul, side_div;
  logic [QUO_W-1:0] fix_quo, fix;
  logic [W-1:0]     fix_rem_unused;

  assign t_plus = {1'b0, plain_mod_r} + (W+1)'(1);
  assign half   = {{(QUO_W-W){1'b0}}, t_plus[W:1]};

  rpsas_mul #(.SW(SIDE)) u_fix_mul (
    .clk(clk), .en(adv), .a(big_mod_r), .b(in_tdata[W-1:0]), .c(half),
    .side_in({in_tdata, in_tuser}), .p(fix_num), .side_out(side_mul)
  );

  rpsas_div #(.SW(SIDE)) u_fix_div (
    .clk(clk), .en(adv), .num(fix_num), .den(plain_mod_r), .side_in(side_mul),
    .quo(fix_quo), .rem(fix_rem_unused), .side_out(side_div)
  );

  assign fix = (plain_mod_r == '0) ? '0 : fix_quo;

  logic [W-1:0] lane_out [MAXL];

  for (genvar j = 0; j < MAXL; j++) begin : g_lane
    if (j < LIMBS) begin : g_on
      rpsas_lane u_lane (
        .clk(clk), .en(adv), .m(side_div[W:1]), .fix(fix),
        .d(side_div[(j+2)*W:(j+1)*W+1]), .sub(side_div[0]),
        .delta(delta_r[j]), .q(limb_q_r[j]), .result(lane_out[j])
      );
    end else begin : g_off
      assign lane_out[j] = '0;
    end
  end

  assign out_tdata = {4'b0, lane_out[2], lane_out[1], lane_out[0]};

endmodule

// ===== src/rpsas_mul.sv =====
// two-stage 60x60 multiply with a 64-bit addend, split into 30-bit partial products
// depends on rpsas_pkg
module rpsas_mul import rpsas_pkg::*; #(
  parameter int unsigned SW = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  logic [QUO_W-1:0] c,
  input  logic [SW-1:0]    side_in,
  output logic [NUM_W-1:0] p,
  output logic [SW-1:0]    side_out
);

  logic [W-1:0]     p00_r, p01_r, p10_r, p11_r;
  logic [QUO_W-1:0] c_r;
  logic [SW-1:0]    side1_r;
  logic [NUM_W-1:0] p_r;
  logic [SW-1:0]    side2_r;
  logic [NUM_W-1:0] sum_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r   <= a[HALF_W-1:0] * b[HALF_W-1:0];
      p01_r   <= a[HALF_W-1:0] * b[W-1:HALF_W];
      p10_r   <= a[W-1:HALF_W] * b[HALF_W-1:0];
      p11_r   <= a[W-1:HALF_W] * b[W-1:HALF_W];
      c_r     <= c;
      side1_r <= side_in;
    end
  end

  always_comb begin
    sum_nxt = {{(NUM_W-W){1'b0}}, p00_r}
            + ({{(NUM_W-W){1'b0}}, p01_r} << HALF_W)
            + ({{(NUM_W-W){1'b0}}, p10_r} << HALF_W)
            + ({{(NUM_W-W){1'b0}}, p11_r} << W)
            + {{(NUM_W-QUO_W){1'b0}}, c_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= sum_nxt;
      side2_r <= side1_r;
    end
  end

  assign p        = p_r;
  assign side_out = side2_r;

endmodule

// ===== src/rpsas_div.sv =====
// pipelined restoring divider, one quotient bit per stage, low 64 quotient bits kept
// depends on rpsas_pkg
module rpsas_div import rpsas_pkg::*; #(
  parameter int unsigned SW = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [W-1:0]     den,
  input  logic [SW-1:0]    side_in,
  output logic [QUO_W-1:0] quo,
  output logic [W-1:0]     rem,
  output logic [SW-1:0]    side_out
);

  logic [W-1:0]     rem_r  [NUM_W];
  logic [NUM_W-1:0] num_r  [NUM_W];
  logic [QUO_W-1:0] quo_r  [NUM_W];
  logic [SW-1:0]    side_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [W-1:0]     rem_in;
    logic [NUM_W-1:0] num_in;
    logic [QUO_W-1:0] quo_in;
    logic [SW-1:0]    side_in_s;
    logic [W:0]       trial;
    logic             ge;
    logic [W:0]       diff;

    if (s == 0) begin : g_first
      assign rem_in    = '0;
      assign num_in    = num;
      assign quo_in    = '0;
      assign side_in_s = side_in;
    end else begin : g_next
      assign rem_in    = rem_r[s-1];
      assign num_in    = num_r[s-1];
      assign quo_in    = quo_r[s-1];
      assign side_in_s = side_r[s-1];
    end

    always_comb begin
      trial = {rem_in, num_in[NUM_W-1]};
      ge    = trial >= {1'b0, den};
      diff  = trial - {1'b0, den};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? diff[W-1:0] : trial[W-1:0];
        num_r[s]  <= {num_in[NUM_W-2:0], 1'b0};
        quo_r[s]  <= {quo_in[QUO_W-2:0], ge};
        side_r[s] <= side_in_s;
      end
    end
  end

  assign quo      = quo_r[NUM_W-1];
  assign rem      = rem_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

// ===== src/rpsas_lane.sv =====
// one rns limb: scale, reduce, then modular add or subtract into the destination
// depends on rpsas_pkg, rpsas_mul, rpsas_div
module rpsas_lane import rpsas_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     m,
  input  logic [QUO_W-1:0] fix,
  input  logic [W-1:0]     d,
  input  logic             sub,
  input  logic [W-1:0]     delta,
  input  logic [W-1:0]     q,
  output logic [W-1:0]     result
);

  logic [NUM_W-1:0] prod;
  logic [W:0]       mside;
  logic [QUO_W-1:0] quo_s_unused, quo_d_unused;
  logic [W-1:0]     s_rem, d_rem, d_raw;
  logic             sub_d;
  logic [W-1:0]     result_r;
  logic [W:0]       sum;
  logic [W:0]       res_nxt;

  rpsas_mul #(.SW(W+1)) u_mul (
    .clk(clk), .en(en), .a(m), .b(delta), .c(fix),
    .side_in({sub, d}), .p(prod), .side_out(mside)
  );

  rpsas_div #(.SW(1)) u_div_s (
    .clk(clk), .en(en), .num(prod), .den(q), .side_in(mside[W]),
    .quo(quo_s_unused), .rem(s_rem), .side_out(sub_d)
  );

  rpsas_div #(.SW(W)) u_div_d (
    .clk(clk), .en(en), .num({{(NUM_W-W){1'b0}}, mside[W-1:0]}), .den(q),
    .side_in(mside[W-1:0]), .quo(quo_d_unused), .rem(d_rem), .side_out(d_raw)
  );

  always_comb begin
    sum = {1'b0, d_rem} + {1'b0, s_rem};
    if (q == '0) begin
      res_nxt = {1'b0, d_raw};
    end else if (sub_d) begin
      res_nxt = (d_rem >= s_rem) ? ({1'b0, d_rem} - {1'b0, s_rem})
                                 : (sum - {1'b0, s_rem} + {1'b0, q} - {1'b0, s_rem});
    end else begin
      res_nxt = (sum >= {1'b0, q}) ? (sum - {1'b0, q}) : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= res_nxt[W-1:0];
    end
  end

  assign result = result_r;

endmodule
